// ----- design/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg - sorted table binary search package
// Shared widths, default table depth and request codes.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  // default number of table entries
  localparam int TABLE_DEPTH_DEF = 1024;

  // field widths fixed by the interface
  localparam int ENTRY_W = 32;
  localparam int INDEX_W = 10;
  localparam int LEN_W   = 11;

  // request codes carried on req_type
  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SEARCH = 1'b1
  } req_type_t;

endpackage

`default_nettype wire

// ----- design/stbs_ram.sv -----
// ----------------------------------------------------------------------------
// stbs_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = stbs_pkg::ENTRY_W,
  parameter int DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/sorted_table_binary_search.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search - binary search over a sorted entry table
// Operation: an accepted search reads and compares one probed entry per
//   cycle from the single RAM read port, then loads the result register; an
//   empty table goes straight to the result. A new request, search or write,
//   is accepted only once the previous search has loaded its result.
// Reset: rst clears the sequencer, the result valid flag and table_len; the
//   table contents are not cleared and hold garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_we,
  input  logic [stbs_pkg::LEN_W-1:0]   cfg_wdata,
  // request channel
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic                         req_type,
  input  logic [stbs_pkg::INDEX_W-1:0] entry_index,
  input  logic signed [stbs_pkg::ENTRY_W-1:0] entry_value,
  input  logic signed [stbs_pkg::ENTRY_W-1:0] search_key,
  // result channel
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         found,
  output logic [stbs_pkg::INDEX_W-1:0] position
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = (AW + 1 > stbs_pkg::LEN_W) ? AW + 1 : stbs_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_PROBE  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  logic [stbs_pkg::LEN_W-1:0]   table_len;
  logic signed [stbs_pkg::ENTRY_W-1:0] key;
  logic [AW:0]                  low, low_next;
  logic [AW:0]                  hi_ex, hi_ex_next;
  logic [AW-1:0]                mid, mid_next;
  logic                         hit, hit_next;

  logic                         req_accept;
  logic                         rsp_take;
  logic                         rsp_load;
  logic [CW-1:0]                len_ext;
  logic [CW-1:0]                len_clamp;
  logic [AW:0]                  len_eff;
  logic [CW-1:0]                idx_ext;
  logic [CW-1:0]                mid_ext;
  logic [AW+1:0]                probe_sum;
  logic                         interval_live;
  logic                         cmp_eq;
  logic                         cmp_gt;

  logic                         wr_en;
  logic                         rd_en;
  logic [stbs_pkg::ENTRY_W-1:0] rd_data;

  // handshakes
  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign rsp_take   = rsp_valid && !rsp_stall;
  assign rsp_load   = (state == S_FINISH) && (!rsp_valid || !rsp_stall);

  // effective length, clamped to the table depth
  assign len_ext   = CW'(table_len);
  assign len_clamp = (len_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : len_ext;
  assign len_eff   = len_clamp[AW:0];

  // write transaction decode
  assign idx_ext = CW'(entry_index);
  assign wr_en   = req_accept && (req_type == stbs_pkg::REQ_WRITE) &&
                   (idx_ext < CW'(TABLE_DEPTH));

  // probed entry against key
  assign cmp_eq = ($signed(rd_data) == key);
  assign cmp_gt = ($signed(rd_data) > key);

  // sequencer and shared interval update
  always_comb begin
    state_next = state;
    low_next   = low;
    hi_ex_next = hi_ex;
    hit_next   = hit;
    rd_en      = 1'b0;

    case (state)
      S_IDLE: begin
        low_next   = '0;
        hi_ex_next = len_eff;
        hit_next   = 1'b0;
      end
      S_PROBE: begin
        if (cmp_eq) begin
          hit_next = 1'b1;
        end else if (cmp_gt) begin
          hi_ex_next = (AW+1)'(mid);
        end else begin
          low_next = (AW+1)'(mid) + 1'b1;
        end
      end
      S_FINISH: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // one adder forms the next probe index
    probe_sum     = {1'b0, low_next} + {1'b0, hi_ex_next} - 1'b1;
    mid_next      = probe_sum[AW:1];
    interval_live = (low_next < hi_ex_next);

    case (state)
      S_IDLE: begin
        if (req_accept && (req_type == stbs_pkg::REQ_SEARCH)) begin
          if (interval_live) begin
            rd_en      = 1'b1;
            state_next = S_PROBE;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_PROBE: begin
        if (!cmp_eq && interval_live) begin
          rd_en = 1'b1;
        end else begin
          state_next = S_FINISH;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      table_len <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        table_len <= cfg_wdata;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_take) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // search datapath registers
  always_ff @(posedge clk) begin
    if (req_accept) begin
      key <= search_key;
    end
    low   <= low_next;
    hi_ex <= hi_ex_next;
    hit   <= hit_next;
    if (rd_en) begin
      mid <= mid_next;
    end
  end

  // result register
  assign mid_ext = CW'(mid);
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      found    <= hit;
      position <= hit ? mid_ext[stbs_pkg::INDEX_W-1:0] : '0;
    end
  end

  // entry table
  stbs_ram #(
    .WIDTH (stbs_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (entry_value),
    .rd_en   (rd_en),
    .rd_addr (mid_next),
    .rd_data (rd_data)
  );

`ifndef NO_ASSERTIONS
  // a probe always sits on a non-empty interval
  a_probe_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (low < hi_ex))
    else $error("probe on empty interval");

  // the probed index lies inside the interval
  a_mid_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (((AW+1)'(mid) >= low) && ((AW+1)'(mid) < hi_ex)))
    else $error("probe index outside interval");

  // a finished search with a free result slot is delivered next cycle
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && !rsp_valid) |=> (rsp_valid && (state == S_IDLE)))
    else $error("finished search not delivered");

  // a miss reports position zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !found) |-> (position == '0))
    else $error("miss with non-zero position");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for sorted_table_binary_search
// Loads sorted tables of several lengths, searches them for hit and miss keys
// and checks every result against a mirror of the table, with random idling
// on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int CLK_PERIOD    = 10;
  localparam int DEPTH         = stbs_pkg::TABLE_DEPTH_DEF;
  localparam int ENTRY_W       = stbs_pkg::ENTRY_W;
  localparam int INDEX_W       = stbs_pkg::INDEX_W;
  localparam int LEN_W         = stbs_pkg::LEN_W;
  localparam int SETTLE_CYCLES = 16;
  localparam int IDLE_LIMIT    = 3000;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_LEN      = 300;
  localparam int PRINT_CAP     = 50;
  localparam int DENSE_MAX     = 128;
  localparam int EDGE_SPAN     = 64;
  localparam int KEY_TRIES     = 16;

  typedef struct packed {
    stbs_pkg::req_type_t kind;
    logic [INDEX_W-1:0]  idx;
    logic [ENTRY_W-1:0]  value;
    logic [ENTRY_W-1:0]  key;
  } lookup_item_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] pos;
  } lookup_answer_t;

  // block ports
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [LEN_W-1:0]    cfg_wdata = '0;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic                req_type = 1'b0;
  logic [INDEX_W-1:0]  entry_index = '0;
  logic signed [ENTRY_W-1:0] entry_value = '0;
  logic signed [ENTRY_W-1:0] search_key = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic                found;
  logic [INDEX_W-1:0]  position;

  // mirror of the block state, updated on accepted transactions
  logic [ENTRY_W-1:0]  entry_mirror [0:DEPTH-1];
  int                  len_mirror = 0;
  // table contents as queued, used to pick keys and to keep probes on
  // entries that have been written
  logic [ENTRY_W-1:0]  entry_plan [0:DEPTH-1];
  bit                  entry_known [0:DEPTH-1];
  logic [ENTRY_W-1:0]  seed_table [0:15];

  lookup_item_t        req_backlog [$];
  lookup_answer_t      lookup_answers [$];
  lookup_item_t        cur;
  bit                  in_flight = 1'b0;

  int send_idle = 0;
  int send_calm = 0;
  int stall_left = 0;
  int recv_calm = 0;
  int hold_left = 0;
  bit held = 1'b0;
  int idle_cycles = 0;

  int mismatches = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int searches_sent = 0;
  int writes_sent = 0;
  int cfg_writes = 0;

  sorted_table_binary_search dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .search_key (search_key),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .found      (found),
    .position   (position)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // binary search over the mirrored table with the mirrored length
  function automatic lookup_answer_t binary_lookup(input logic [ENTRY_W-1:0] key);
    lookup_answer_t ans;
    int lo;
    int hi;
    int mid;
    ans.hit = 1'b0;
    ans.pos = '0;
    lo = 0;
    hi = ((len_mirror > DEPTH) ? DEPTH : len_mirror) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (entry_mirror[mid] == key) begin
        ans.hit = 1'b1;
        ans.pos = mid[INDEX_W-1:0];
        break;
      end else if ($signed(entry_mirror[mid]) > $signed(key)) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return ans;
  endfunction

  // true when every entry probed for key over n entries has been written
  function automatic bit probes_known(input logic [ENTRY_W-1:0] key, input int n);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (!entry_known[mid]) return 1'b0;
      if (entry_plan[mid] == key) return 1'b1;
      if ($signed(entry_plan[mid]) > $signed(key)) hi = mid - 1;
      else lo = mid + 1;
    end
    return 1'b1;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap;
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void queue_write(input int idx, input logic [ENTRY_W-1:0] value);
    lookup_item_t it;
    it.kind  = stbs_pkg::REQ_WRITE;
    it.idx   = idx[INDEX_W-1:0];
    it.value = value;
    it.key   = $urandom;
    entry_plan[idx]  = value;
    entry_known[idx] = 1'b1;
    req_backlog.push_back(it);
  endfunction

  function automatic void queue_search(input logic [ENTRY_W-1:0] key);
    lookup_item_t it;
    it.kind  = stbs_pkg::REQ_SEARCH;
    it.idx   = INDEX_W'($urandom_range(0, DEPTH - 1));
    it.value = $urandom;
    it.key   = key;
    req_backlog.push_back(it);
  endfunction

  // wait for the backlog and all results to drain, then let the block settle
  task automatic wait_idle;
    while (req_backlog.size() != 0 || in_flight || lookup_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_len(input int len_val);
    wait_idle();
    cfg_wdata <= len_val[LEN_W-1:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    len_mirror = len_val;
    cfg_writes++;
  endtask

  // ascending random entries over indices 0..n-1, with some repeats; a long
  // table is written only at both ends and at every sixteenth index
  task automatic fill_sorted(input int n);
    longint v;
    longint step_max;
    int i;
    v = -64'sd2147483648;
    if ($urandom_range(0, 3) != 0)
      v = v + longint'($urandom_range(0, 32'h7FFF_FFFF));
    step_max = (64'sd2147483647 - v) / n;
    for (i = 0; i < n; i++) begin
      if (n <= DENSE_MAX || i < EDGE_SPAN || i >= n - EDGE_SPAN || (i % 16) == 15)
        queue_write(i, v[ENTRY_W-1:0]);
      if ($urandom_range(0, 4) != 0)
        v = v + (longint'($urandom) % (step_max + 1));
    end
  endtask

  // one setting of table_len followed by a batch of searches
  task automatic run_phase(input int len_val, input int searches, input bit refill,
                           input bit noisy);
    int n;
    int i;
    int tries;
    int pick;
    int idx;
    bit ok;
    logic [ENTRY_W-1:0] key;
    n = (len_val > DEPTH) ? DEPTH : len_val;
    if (n > 0 && refill) fill_sorted(n);
    set_len(len_val);
    for (i = 0; i < searches; i++) begin
      // stray writes break the ordering on purpose
      if (noisy && $urandom_range(0, 7) == 0)
        queue_write($urandom_range(0, DEPTH - 1), $urandom);
      // keep only keys whose probes land on written entries
      ok = 1'b0;
      for (tries = 0; tries < KEY_TRIES && !ok; tries++) begin
        pick = $urandom_range(0, 9);
        if (n == 0 || pick >= 7) begin
          if (pick == 9)
            key = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          else
            key = $urandom;
        end else begin
          idx = $urandom_range(0, n - 1);
          key = entry_known[idx] ? entry_plan[idx] : $urandom;
          if (pick == 5) key = key + 1;
          else if (pick == 6) key = key - 1;
        end
        ok = probes_known(key, n);
      end
      if (ok) queue_search(key);
    end
  endtask

  // request driver: predicts on accept, then presents the next transaction
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        in_flight = 1'b0;
        if (cur.kind == stbs_pkg::REQ_WRITE) begin
          entry_mirror[cur.idx] = cur.value;
          writes_sent++;
        end else begin
          lookup_answers.push_back(binary_lookup(cur.key));
          searches_sent++;
        end
      end
      if (req_valid && req_stall) begin
        // stalled payload is held
      end else if (send_idle != 0) begin
        req_valid <= 1'b0;
        send_idle--;
      end else if (req_backlog.size() != 0) begin
        cur = req_backlog.pop_front();
        in_flight = 1'b1;
        req_type    <= cur.kind;
        entry_index <= cur.idx;
        entry_value <= cur.value;
        search_key  <= cur.key;
        req_valid   <= 1'b1;
        if (send_calm != 0) begin
          send_calm--;
        end else if ($urandom_range(0, 49) == 0) begin
          send_calm = $urandom_range(30, 80);
        end else begin
          send_idle = pick_gap();
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result monitor: checks each accepted result and drives the stall
  always @(posedge clk) begin
    lookup_answer_t want;
    int len;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (lookup_answers.size() == 0) begin
          report_mismatch($sformatf("result found=%0b position=%0d with none expected",
                                    found, position));
        end else begin
          want = lookup_answers.pop_front();
          if (found !== want.hit)
            report_mismatch($sformatf("result %0d found=%b expected %b",
                                      results_seen, found, want.hit));
          if (position !== want.pos)
            report_mismatch($sformatf("result %0d position=%0d expected %0d",
                                      results_seen, position, want.pos));
        end
        results_seen++;
        if (found === 1'b1) hits_seen++;
        // one long hold-off so the block backs up into the request side
        if (results_seen == HOLD_AT && !held) begin
          held = 1'b1;
          hold_left = HOLD_LEN;
        end
      end
      if (hold_left != 0) begin
        rsp_stall <= 1'b1;
        hold_left--;
      end else if (stall_left != 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else if (recv_calm != 0) begin
        rsp_stall <= 1'b0;
        recv_calm--;
      end else if ($urandom_range(0, 49) == 0) begin
        rsp_stall <= 1'b0;
        recv_calm = $urandom_range(30, 80);
      end else begin
        len = pick_gap();
        rsp_stall <= (len != 0);
        if (len != 0) stall_left = len - 1;
      end
    end
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("** sorted_table_binary_search: FAILED **");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int i;
    seed_table = '{32'h8000_0000, 32'hFFF0_BDC0, 32'hFFFF_FFFB, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0000_0007,
                   32'h0000_0007, 32'h0000_0064, 32'h0000_0FFF, 32'h0001_0000,
                   32'h000F_4240, 32'h4000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table straight out of reset
    queue_search(32'h0000_0000);
    queue_search(32'h8000_0000);

    // small table with both extremes and repeated entries
    for (i = 0; i < 16; i++) queue_write(i, seed_table[i]);
    set_len(16);
    queue_search(32'h8000_0000);
    queue_search(32'h7FFF_FFFF);
    queue_search(32'hFFFF_FFFF);
    queue_search(32'h0000_0007);
    queue_search(32'h0000_0000);
    queue_search(32'h4000_0000);
    queue_search(32'hFFFF_FFFE);
    queue_search(32'h0000_0008);
    queue_search(32'h7FFF_FFFD);
    queue_search(32'h8000_0001);

    // random phases over a range of lengths
    run_phase(1, 15, 1'b1, 1'b0);
    run_phase(2, 15, 1'b1, 1'b0);
    run_phase(3, 15, 1'b1, 1'b1);
    run_phase(DEPTH, 70, 1'b1, 1'b0);
    run_phase(2047, 40, 1'b0, 1'b1);
    run_phase($urandom_range(4, 40), 40, 1'b1, 1'b0);
    run_phase($urandom_range(4, 40), 40, 1'b1, 1'b1);
    run_phase($urandom_range(5, 64), 40, 1'b1, 1'b0);
    run_phase($urandom_range(100, DEPTH - 1), 40, 1'b0, 1'b1);
    run_phase(0, 15, 1'b0, 1'b0);
    run_phase($urandom_range(1, DEPTH), 30, 1'b0, 1'b0);

    wait_idle();
    $display("run covered %0d searches (%0d found) and %0d table writes",
             searches_sent, hits_seen, writes_sent);
    $display("over %0d length settings from empty through full and over range",
             cfg_writes);
    if (mismatches == 0) begin
      $display("** sorted_table_binary_search: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** sorted_table_binary_search: FAILED **");
    end
    $finish;
  end

endmodule
